@@ src/twb_pkg.sv @@
// Shared types, constants and the control program for the task watchdog bank.
// No dependencies; imported by twb_sequencer and task_watchdog_bank_with_timers_unit.
package twb_pkg;

    localparam int NUM_WATCHDOGS      = 8;
    localparam int NUM_TIMERS         = 2;
    localparam int WDG_IDX_W          = (NUM_WATCHDOGS > 1) ? $clog2(NUM_WATCHDOGS) : 1;

    localparam int SECONDS_PER_DAY    = 86400;
    localparam int TICKS_PER_TIMEOUT  = 6;
    localparam int RESET_TICK_SECONDS = 5;
    localparam logic [15:0] WDG_RESET_VALUE = 16'(RESET_TICK_SECONDS * TICKS_PER_TIMEOUT);
    localparam logic [19:0] DAY_RESET_VALUE = 20'(SECONDS_PER_DAY / RESET_TICK_SECONDS);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_SECONDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY_TICKS    = 2'd1;

    // request opcodes
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_KICK      = 2'd1;
    localparam logic [1:0] OP_LOAD_POLL = 2'd2;
    localparam logic [1:0] OP_LOAD_DIAL = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  channel;
        logic [31:0] load_value;
    } req_t;

    typedef struct packed {
        logic        watchdog_expired;
        logic [2:0]  expired_channel;
        logic        daily_reset;
        logic [15:0] poll_remaining;
        logic [31:0] dial_remaining;
    } rsp_t;

    // micro-operations driving the datapath
    typedef enum logic [3:0] {
        UOP_IDLE,
        UOP_WDG_DEC,
        UOP_POLL_DEC,
        UOP_DIAL_DEC,
        UOP_DAY,
        UOP_KICK,
        UOP_POLL_LOAD,
        UOP_DIAL_LOAD,
        UOP_RESULT
    } uop_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_LOOP,
        JMP_DISPATCH
    } jmp_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t ST_IDLE      = 4'd0;
    localparam step_t ST_WDG       = 4'd1;
    localparam step_t ST_POLL      = 4'd2;
    localparam step_t ST_DIAL      = 4'd3;
    localparam step_t ST_DAY       = 4'd4;
    localparam step_t ST_KICK      = 4'd5;
    localparam step_t ST_POLL_LOAD = 4'd6;
    localparam step_t ST_DIAL_LOAD = 4'd7;
    localparam step_t ST_RESULT    = 4'd8;

    typedef struct packed {
        uop_t  op;
        jmp_t  jmp;
        step_t target;
    } ucode_t;

    // sequencer -> datapath
    typedef struct packed {
        uop_t op;
        logic busy;
        logic accept;
    } ctrl_t;

    // datapath/ports -> sequencer
    typedef struct packed {
        logic       start;
        logic       frozen;
        logic [1:0] opcode;
        logic       idx_last;
    } stat_t;

    // control program: one word per step
    function automatic ucode_t ucode_rom(step_t s);
        ucode_t w;
        unique case (s)
            ST_IDLE:      w = '{op: UOP_IDLE,      jmp: JMP_DISPATCH, target: ST_IDLE};
            ST_WDG:       w = '{op: UOP_WDG_DEC,   jmp: JMP_LOOP,     target: ST_WDG};
            ST_POLL:      w = '{op: UOP_POLL_DEC,  jmp: JMP_NEXT,     target: ST_IDLE};
            ST_DIAL:      w = '{op: UOP_DIAL_DEC,  jmp: JMP_NEXT,     target: ST_IDLE};
            ST_DAY:       w = '{op: UOP_DAY,       jmp: JMP_GOTO,     target: ST_RESULT};
            ST_KICK:      w = '{op: UOP_KICK,      jmp: JMP_GOTO,     target: ST_RESULT};
            ST_POLL_LOAD: w = '{op: UOP_POLL_LOAD, jmp: JMP_GOTO,     target: ST_RESULT};
            ST_DIAL_LOAD: w = '{op: UOP_DIAL_LOAD, jmp: JMP_GOTO,     target: ST_RESULT};
            ST_RESULT:    w = '{op: UOP_RESULT,    jmp: JMP_GOTO,     target: ST_IDLE};
            default:      w = '{op: UOP_IDLE,      jmp: JMP_GOTO,     target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ src/twb_sequencer.sv @@
// Microcoded step sequencer: step counter, control word lookup and jumps.
// Depends on twb_pkg (ucode_rom, ctrl_t, stat_t).
module twb_sequencer
    import twb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;

    assign word = ucode_rom(step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        step_next   = step_reg + 1'b1;
        ctrl.op     = word.op;
        ctrl.busy   = (step_reg != ST_IDLE);
        ctrl.accept = (step_reg == ST_IDLE) && stat.start;
        unique case (word.jmp)
            JMP_NEXT: step_next = step_reg + 1'b1;
            JMP_GOTO: step_next = word.target;
            // repeat the step until the last watchdog has been walked
            JMP_LOOP: step_next = stat.idx_last ? step_reg + 1'b1 : word.target;
            JMP_DISPATCH:
            begin
                priority if (!stat.start)
                begin
                    step_next = ST_IDLE;
                end
                else if (stat.frozen)
                begin
                    step_next = ST_RESULT;
                end
                else
                begin
                    unique case (stat.opcode)
                        OP_TICK:      step_next = ST_WDG;
                        OP_KICK:      step_next = ST_KICK;
                        OP_LOAD_POLL: step_next = ST_POLL_LOAD;
                        OP_LOAD_DIAL: step_next = ST_DIAL_LOAD;
                        default:      step_next = ST_IDLE;
                    endcase
                end
            end
            default: step_next = ST_IDLE;
        endcase
    end

endmodule

@@ src/task_watchdog_bank_with_timers_unit.sv @@
// Top level of the task watchdog bank: datapath, registers and result port.
// Depends on twb_pkg and twb_sequencer.

// A request is taken when start is high and busy is low. In a tick, one
// shared saturating subtractor walks the watchdogs one per cycle, then the
// poll timer, the dial timer and the day counter each take a step. Kick and
// timer loads do their own step and then the result step; once a watchdog
// has expired every request goes straight to the result step. The result
// appears on rsp with done high for exactly one cycle, in the cycle in
// which busy falls, and must be captured there: there is no way to hold it.
// A new request may be started in that same cycle. Configuration writes
// are always ready and are to be issued while idle.
module task_watchdog_bank_with_timers_unit
    import twb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  req,
    output logic                  done,
    output rsp_t                  rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_t ctrl;
    stat_t stat;

    logic [15:0]          wdg_reg [NUM_WATCHDOGS];
    logic [WDG_IDX_W-1:0] idx_reg;
    logic [31:0]          poll_reg;
    logic [31:0]          dial_reg;
    logic [19:0]          day_reg;
    logic                 expired_reg;
    logic [2:0]           exp_idx_reg;
    logic                 pulse_reg;
    logic [7:0]           tick_sec_reg;
    logic [19:0]          day_ticks_reg;
    req_t                 req_reg;
    logic                 done_reg;
    rsp_t                 rsp_reg;

    logic                 idx_last;
    logic                 kick_ok;
    logic [31:0]          sub_opnd;
    logic [31:0]          sub_res;

    twb_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign idx_last      = (idx_reg == WDG_IDX_W'(NUM_WATCHDOGS - 1));
    assign stat.start    = start;
    assign stat.frozen   = expired_reg;
    assign stat.opcode   = req.opcode;
    assign stat.idx_last = idx_last;

    assign busy      = ctrl.busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign kick_ok   = ({29'd0, req_reg.channel} < 32'(NUM_WATCHDOGS));

    // shared saturating subtractor
    always_comb
    begin
        unique case (ctrl.op)
            UOP_WDG_DEC:  sub_opnd = {16'd0, wdg_reg[idx_reg]};
            UOP_POLL_DEC: sub_opnd = poll_reg;
            default:      sub_opnd = dial_reg;
        endcase
        sub_res = (sub_opnd > {24'd0, tick_sec_reg}) ? sub_opnd - {24'd0, tick_sec_reg} : 32'd0;
    end

    // hold the request for the whole sequence
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WATCHDOGS; i++)
            begin
                wdg_reg[i] <= WDG_RESET_VALUE;
            end
            idx_reg       <= '0;
            poll_reg      <= '0;
            dial_reg      <= '0;
            day_reg       <= DAY_RESET_VALUE;
            expired_reg   <= 1'b0;
            exp_idx_reg   <= '0;
            pulse_reg     <= 1'b0;
            tick_sec_reg  <= 8'(RESET_TICK_SECONDS);
            day_ticks_reg <= DAY_RESET_VALUE;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= (ctrl.op == UOP_RESULT);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TICK_SECONDS)
                begin
                    tick_sec_reg <= cfg_data[7:0];
                end
                else if (cfg_index == CFG_DAY_TICKS)
                begin
                    day_ticks_reg <= cfg_data;
                end
            end
            unique case (ctrl.op)
                UOP_IDLE:
                begin
                    idx_reg <= '0;
                    if (ctrl.accept)
                    begin
                        pulse_reg <= 1'b0;
                    end
                end
                UOP_WDG_DEC:
                begin
                    wdg_reg[idx_reg] <= sub_res[15:0];
                    // latch only the first watchdog to hit zero
                    if (sub_res[15:0] == 16'd0 && !expired_reg)
                    begin
                        expired_reg <= 1'b1;
                        exp_idx_reg <= 3'(idx_reg);
                    end
                    idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
                end
                UOP_POLL_DEC:
                begin
                    if (!expired_reg && NUM_TIMERS > 0)
                    begin
                        poll_reg <= sub_res;
                    end
                end
                UOP_DIAL_DEC:
                begin
                    if (!expired_reg && NUM_TIMERS > 1)
                    begin
                        dial_reg <= sub_res;
                    end
                end
                UOP_DAY:
                begin
                    if (!expired_reg)
                    begin
                        if (day_reg <= 20'd1)
                        begin
                            pulse_reg <= 1'b1;
                            day_reg   <= day_ticks_reg;
                        end
                        else
                        begin
                            day_reg <= day_reg - 1'b1;
                        end
                    end
                end
                UOP_KICK:
                begin
                    if (kick_ok)
                    begin
                        wdg_reg[WDG_IDX_W'(req_reg.channel)] <= req_reg.load_value[15:0];
                    end
                end
                UOP_POLL_LOAD: poll_reg <= {16'd0, req_reg.load_value[15:0]};
                UOP_DIAL_LOAD: dial_reg <= req_reg.load_value;
                UOP_RESULT:    ;
                default:       ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctrl.op == UOP_RESULT)
        begin
            rsp_reg.watchdog_expired <= expired_reg;
            rsp_reg.expired_channel  <= expired_reg ? exp_idx_reg : 3'd0;
            rsp_reg.daily_reset      <= pulse_reg;
            rsp_reg.poll_remaining   <= poll_reg[15:0];
            rsp_reg.dial_remaining   <= dial_reg;
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a request is still in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start the sequence");

    a_expired_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        expired_reg |=> expired_reg)
        else $error("expired flag dropped without reset");

    a_frozen_timers: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(expired_reg) && expired_reg) |-> ($stable(poll_reg) && $stable(dial_reg)))
        else $error("timers moved after expiry");

    a_pulse_not_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.daily_reset) |-> !rsp.watchdog_expired)
        else $error("daily reset pulse reported together with expiry");

endmodule
